@@ src/merge_sort_engine_macros.svh @@
// Assertion macros shared by the merge sort engine RTL.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mse_pkg.sv @@
// Package for the merge sort engine: default sizes, field widths and the FSM type.
// Depends on nothing.
package mse_pkg;

    // Default store depth and element width.
    localparam int MSE_MAX_ELEMENTS = 64;
    localparam int MSE_DATA_WIDTH   = 32;

    // Fixed width of the value and sorted_value ports.
    localparam int MSE_IO_WIDTH = 32;

    // Control states of the engine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_MERGE,
        S_OUT
    } t_state;

endpackage

@@ src/mse_ram.sv @@
// Generic synchronous RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr1,
    output logic [WIDTH-1:0]         o_rd_data0,
    output logic [WIDTH-1:0]         o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data0 <= r_mem[i_rd_addr0];
        o_rd_data1 <= r_mem[i_rd_addr1];
    end

endmodule

@@ src/merge_sort_engine.sv @@
// Merge sort engine: loads one item per cycle while not busy; after the closing item it sorts
// n items by bottom-up merge passes, P = ceil(log2 n), one merged item per cycle within a
// pass through two read ports on the source buffer, then emits n registered results, one
// per cycle. busy is high from the closing item until the last result is read out;
// results cannot be stalled. Reset clears the control state and the fill count, not the buffers.
`include "merge_sort_engine_macros.svh"

module merge_sort_engine import mse_pkg::*; #(
    parameter int MAX_ELEMENTS = MSE_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = MSE_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [MSE_IO_WIDTH-1:0] i_value,
    input  logic                           i_last,
    output logic                           o_valid,
    output logic signed [MSE_IO_WIDTH-1:0] o_sorted_value,
    output logic                           o_last_out
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    // Index arithmetic width: room for lo + 2*width without overflow.
    localparam int CW = AW + 2;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] ZERO_C = CW'(0);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [CW-1:0] TWO_C  = CW'(2);

    // Sign-extend or truncate a port value to the element width.
    function automatic logic [DATA_WIDTH-1:0] f_to_word(input logic [MSE_IO_WIDTH-1:0] v);
        logic [DATA_WIDTH+MSE_IO_WIDTH-1:0] t;
        t = {{DATA_WIDTH{v[MSE_IO_WIDTH-1]}}, v};
        return t[DATA_WIDTH-1:0];
    endfunction

    // Zero-extend or truncate an element to the port width.
    function automatic logic [MSE_IO_WIDTH-1:0] f_to_port(input logic [DATA_WIDTH-1:0] w);
        logic [DATA_WIDTH+MSE_IO_WIDTH-1:0] t;
        t = {{MSE_IO_WIDTH{1'b0}}, w};
        return t[MSE_IO_WIDTH-1:0];
    endfunction

    function automatic logic [CW-1:0] f_min(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_width, n_width;
    logic [CW-1:0]   r_mid, n_mid;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_l, n_l;
    logic [CW-1:0]   r_r, n_r;
    logic [CW-1:0]   r_t, n_t;
    logic            r_src, n_src;
    logic            r_valid, n_valid;
    logic [MSE_IO_WIDTH-1:0] r_sorted, n_sorted;
    logic            r_last, n_last;

    logic                  a_wr_en, b_wr_en;
    logic [AW-1:0]         a_wr_addr;
    logic [DATA_WIDTH-1:0] a_wr_data;
    logic [DATA_WIDTH-1:0] a_q0, a_q1, b_q0, b_q1;
    logic [DATA_WIDTH-1:0] l_val, r_val, m_val;
    logic                  take_left;
    logic [CW-1:0]         lo_next, wid2;

    // Ping-pong buffers; both read at the same two addresses, selected by r_src.
    mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMENTS)) u_buf_a (
        .i_clk      (i_clk),
        .i_wr_en    (a_wr_en),
        .i_wr_addr  (a_wr_addr),
        .i_wr_data  (a_wr_data),
        .i_rd_addr0 (n_l[AW-1:0]),
        .i_rd_addr1 (n_r[AW-1:0]),
        .o_rd_data0 (a_q0),
        .o_rd_data1 (a_q1)
    );

    mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMENTS)) u_buf_b (
        .i_clk      (i_clk),
        .i_wr_en    (b_wr_en),
        .i_wr_addr  (r_t[AW-1:0]),
        .i_wr_data  (m_val),
        .i_rd_addr0 (n_l[AW-1:0]),
        .i_rd_addr1 (n_r[AW-1:0]),
        .o_rd_data0 (b_q0),
        .o_rd_data1 (b_q1)
    );

    // Heads of the left and right runs and the merge decision; ties go to the right run.
    assign l_val     = r_src ? b_q0 : a_q0;
    assign r_val     = r_src ? b_q1 : a_q1;
    assign take_left = (r_l < r_mid) && ((r_r >= r_hi) || ($signed(l_val) < $signed(r_val)));
    assign m_val     = take_left ? l_val : r_val;
    assign lo_next   = r_hi;
    assign wid2      = r_width << 1;

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_sorted_value = r_sorted;
    assign o_last_out     = r_last;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= ZERO_C;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Sort bookkeeping and result payload.
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_width  <= n_width;
        r_mid    <= n_mid;
        r_hi     <= n_hi;
        r_l      <= n_l;
        r_r      <= n_r;
        r_t      <= n_t;
        r_src    <= n_src;
        r_sorted <= n_sorted;
        r_last   <= n_last;
    end

    // Next state: load, pass setup, merge one item per cycle, read out.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_width   = r_width;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_l       = r_l;
        n_r       = r_r;
        n_t       = r_t;
        n_src     = r_src;
        n_valid   = 1'b0;
        n_sorted  = f_to_port(l_val);
        n_last    = 1'b0;
        a_wr_en   = 1'b0;
        b_wr_en   = 1'b0;
        a_wr_addr = r_t[AW-1:0];
        a_wr_data = m_val;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    a_wr_en   = 1'b1;
                    a_wr_addr = r_count[AW-1:0];
                    a_wr_data = f_to_word(i_value);
                    // A full store closes the set as if the item were marked last.
                    if (i_last || (r_count + ONE_C == MAX_C)) begin
                        n_n     = r_count + ONE_C;
                        n_count = ZERO_C;
                        n_width = ONE_C;
                        n_src   = 1'b0;
                        n_l     = ZERO_C;
                        n_t     = ZERO_C;
                        n_mid   = f_min(ONE_C, r_count + ONE_C);
                        n_hi    = f_min(TWO_C, r_count + ONE_C);
                        n_r     = f_min(ONE_C, r_count + ONE_C);
                        n_state = S_PREP;
                    end else begin
                        n_count = r_count + ONE_C;
                    end
                end
            end
            S_PREP: begin
                // Read addresses come from r_l and r_r; all earlier writes have landed.
                if (r_n == ONE_C) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                b_wr_en = !r_src;
                a_wr_en = r_src;
                n_t     = r_t + ONE_C;
                if (take_left) begin
                    n_l = r_l + ONE_C;
                end else begin
                    n_r = r_r + ONE_C;
                end
                // End of a run pair: move on to the next pair, the next pass or readout.
                if (r_t + ONE_C == r_hi) begin
                    if (lo_next >= r_n) begin
                        n_src = !r_src;
                        n_l   = ZERO_C;
                        if (wid2 >= r_n) begin
                            n_state = S_OUT;
                        end else begin
                            n_width = wid2;
                            n_t     = ZERO_C;
                            n_mid   = f_min(wid2, r_n);
                            n_hi    = f_min(wid2 << 1, r_n);
                            n_r     = f_min(wid2, r_n);
                            n_state = S_PREP;
                        end
                    end else begin
                        n_l   = lo_next;
                        n_t   = lo_next;
                        n_mid = f_min(lo_next + r_width, r_n);
                        n_hi  = f_min(lo_next + wid2, r_n);
                        n_r   = f_min(lo_next + r_width, r_n);
                    end
                end
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_l     = r_l + ONE_C;
                if (r_l + ONE_C == r_n) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Every readout cycle produces exactly one result strobe.
    `MSE_ASSERT_NEXT(a_out_strobe, r_state == S_OUT, o_valid, "readout cycle gave no result")
    // The final result appears only once the engine is free again.
    `MSE_ASSERT_NOW(a_last_idle, o_valid && o_last_out, r_state == S_IDLE,
        "final result while engine busy")
    // The merge write pointer stays inside the current run pair.
    `MSE_ASSERT_NOW(a_t_in_run, r_state == S_MERGE, r_t < r_hi, "merge write past run end")
    // Read pointers never pass their run limits.
    `MSE_ASSERT_NOW(a_heads, r_state == S_MERGE, (r_l <= r_mid) && (r_r <= r_hi),
        "run head past its limit")
    // Filling the last slot always closes the set.
    `MSE_ASSERT_NEXT(a_full_close, start && !busy && (r_count + ONE_C == MAX_C),
        r_state == S_PREP, "full store did not close the set")

endmodule
